// ===== src/cdq_pkg.sv =====
// shared types and constants of the circular deque with search
// no dependencies; every other file of the block depends on this package
package cdq_pkg;

  // default geometry, handed to the top level parameters as their defaults
  localparam int DEPTH_DEFAULT      = 16;
  localparam int VALUE_BITS_DEFAULT = 8;
  localparam int MODE_BITS          = 3;

  // request operation codes
  typedef enum logic [MODE_BITS-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_PEEK_FRONT = 3'd3,
    MODE_CONTAINS   = 3'd4
  } mode_t;

  // what every cell of the row does at a clock edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_SHIFT_IN,
    CELL_SHIFT_OUT
  } cell_op_t;

  // control handed to one cell
  typedef struct packed {
    cell_op_t op;
    logic     at_tail;
    logic     occupied;
  } cell_ctrl_t;

endpackage

// ===== src/cdq_if.sv =====
// request and response channel interfaces of the circular deque with search
// depends on cdq_pkg for the default value width and the mode width
interface cdq_req_if #(
  parameter int VALUE_BITS = cdq_pkg::VALUE_BITS_DEFAULT
);
  logic                           valid;
  logic                           ready;
  logic [cdq_pkg::MODE_BITS-1:0]  mode;
  logic [VALUE_BITS-1:0]          value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface cdq_rsp_if #(
  parameter int VALUE_BITS = cdq_pkg::VALUE_BITS_DEFAULT
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value_out;
  logic                  value_valid;
  logic                  found;
  logic                  dropped;
  logic                  is_empty;
  logic                  is_full;

  modport source (output valid, output value_out, output value_valid, output found,
                  output dropped, output is_empty, output is_full, input ready);
  modport sink   (input valid, input value_out, input value_valid, input found,
                  input dropped, input is_empty, input is_full, output ready);
endinterface

// ===== src/circular_deque_with_search.sv =====
// top level of the circular deque with search: fill count, request decode,
// cell row and response register; depends on cdq_pkg, cdq_if and cdq_cell
//
// The deque takes one request per clock cycle unless its held response is not
// yet taken, answering each in the next cycle from an output register; a new
// request is taken in the same cycle that the previous response is taken. The
// front value always sits in the first cell of a row of DEPTH cells: a push at
// the front shifts the row by one cell toward the back, a pop shifts it toward
// the front, and a push at the back writes the cell named by the fill count.
// Every cell compares its value with the search key, so a contains query is
// settled in the same cycle. A push into a full deque is dropped and flagged;
// a pop or peek of an empty deque returns value_valid low. No clearing pass
// is needed after reset.
module circular_deque_with_search #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEFAULT,
  parameter int VALUE_BITS = cdq_pkg::VALUE_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  cdq_req_if.sink    req,
  cdq_rsp_if.source  rsp
);
  import cdq_pkg::*;

  localparam int COUNT_BITS = $clog2(DEPTH + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(DEPTH);

  logic [COUNT_BITS-1:0] count, count_next;
  logic                  accept;
  logic                  full, empty;
  cell_op_t              row_op;
  logic [VALUE_BITS-1:0] data [DEPTH];
  logic [DEPTH-1:0]      match;

  logic [VALUE_BITS-1:0] value_out_next;
  logic                  value_valid_next, found_next, dropped_next;

  // handshake: the output register frees up when its response is taken
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign full  = (count == COUNT_FULL);
  assign empty = (count == '0);

  // request decode
  always_comb begin
    row_op           = CELL_HOLD;
    count_next       = count;
    value_out_next   = '0;
    value_valid_next = 1'b0;
    found_next       = 1'b0;
    dropped_next     = 1'b0;
    if (accept) begin
      case (mode_t'(req.mode))
        MODE_PUSH_BACK: begin
          if (full) begin
            dropped_next = 1'b1;
          end else begin
            row_op     = CELL_APPEND;
            count_next = count + 1'b1;
          end
        end
        MODE_PUSH_FRONT: begin
          if (full) begin
            dropped_next = 1'b1;
          end else begin
            row_op     = CELL_SHIFT_IN;
            count_next = count + 1'b1;
          end
        end
        MODE_POP_FRONT: begin
          if (!empty) begin
            value_out_next   = data[0];
            value_valid_next = 1'b1;
            row_op           = CELL_SHIFT_OUT;
            count_next       = count - 1'b1;
          end
        end
        MODE_PEEK_FRONT: begin
          if (!empty) begin
            value_out_next   = data[0];
            value_valid_next = 1'b1;
          end
        end
        MODE_CONTAINS: begin
          found_next = |match;
        end
        default: begin
          row_op = CELL_HOLD;
        end
      endcase
    end
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t            ctrl;
    logic [VALUE_BITS-1:0] left_in, right_in;

    assign ctrl.op       = row_op;
    assign ctrl.at_tail  = (count == COUNT_BITS'(i));
    assign ctrl.occupied = (COUNT_BITS'(i) < count);

    if (i == 0) begin : g_first
      assign left_in = req.value;
    end else begin : g_inner_left
      assign left_in = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_in = data[i];
    end else begin : g_inner_right
      assign right_in = data[i+1];
    end

    cdq_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .key      (req.value),
      .left_in  (left_in),
      .right_in (right_in),
      .data     (data[i]),
      .match    (match[i])
    );
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.value_out   <= value_out_next;
      rsp.value_valid <= value_valid_next;
      rsp.found       <= found_next;
      rsp.dropped     <= dropped_next;
      rsp.is_empty    <= (count_next == '0);
      rsp.is_full     <= (count_next == COUNT_FULL);
    end
  end

`ifndef SYNTHESIS
  // fill count never passes the depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_FULL)
    else $error("fill count above depth");

  // a dropped push is only reported on a full deque
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.dropped |-> rsp.is_full && !rsp.value_valid)
    else $error("dropped push without full deque");

  // empty and full never reported together
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.is_empty && rsp.is_full))
    else $error("empty and full both set");

  // popping the last value empties the deque
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    accept && (req.mode == MODE_POP_FRONT) && (count == COUNT_BITS'(1))
    |=> (count == '0) && rsp.is_empty && rsp.value_valid)
    else $error("pop of last value did not empty the deque");

  // a contains query on an empty deque finds nothing
  a_empty_search: assert property (@(posedge clk) disable iff (rst)
    accept && (req.mode == MODE_CONTAINS) && empty |=> !rsp.found)
    else $error("search matched in empty deque");
`endif

endmodule

// ===== src/cdq_cell.sv =====
// one storage cell of the deque row: holds a value, shifts with its neighbors
// and compares its value against the search key; depends on cdq_pkg
module cdq_cell #(
  parameter int VALUE_BITS = cdq_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                   clk,
  input  cdq_pkg::cell_ctrl_t    ctrl,
  input  logic [VALUE_BITS-1:0]  key,
  input  logic [VALUE_BITS-1:0]  left_in,
  input  logic [VALUE_BITS-1:0]  right_in,
  output logic [VALUE_BITS-1:0]  data,
  output logic                   match
);
  import cdq_pkg::*;

  logic [VALUE_BITS-1:0] data_next;

  // next value from the row operation
  always_comb begin
    data_next = data;
    case (ctrl.op)
      CELL_APPEND:    if (ctrl.at_tail) data_next = key;
      CELL_SHIFT_IN:  data_next = left_in;
      CELL_SHIFT_OUT: data_next = right_in;
      default:        data_next = data;
    endcase
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // search compare, gated by occupancy
  assign match = ctrl.occupied && (data == key);

endmodule
